// ===== rtl/ppt_pkg.sv =====
// Shared constants, codes and types of the promotable priority table.
package ppt_pkg;

    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int ID_BITS       = 16;
    localparam int PRIORITY_BITS = 16;
    localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W         = ID_BITS + 1;

    typedef logic [2:0]               t_op;
    typedef logic [1:0]               t_status;
    typedef logic [ID_BITS-1:0]       t_id;
    typedef logic [PRIORITY_BITS-1:0] t_prio;
    typedef logic [PAYLOAD_BITS-1:0]  t_payload;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    localparam t_op OP_ADD     = 3'd0;
    localparam t_op OP_PROMOTE = 3'd1;
    localparam t_op OP_POP     = 3'd2;
    localparam t_op OP_PEEK    = 3'd3;
    localparam t_op OP_LOOKUP  = 3'd4;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_UNKNOWN = 2'd1;
    localparam t_status ST_EMPTY   = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

    // Token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic     vld;
        t_op      op;
        t_id      key;
        t_id      new_id;
        t_payload payload;
        logic     add_en;
        logic     placed;
        logic     hit;
        t_idx     best_idx;
        t_id      r_id;
        t_prio    r_prio;
        t_payload r_pay;
    } t_tok;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic clr;
        t_idx clr_idx;
    } t_ctl;

endpackage

// ===== rtl/ppt_ifs.sv =====
// Valid/ready channel interfaces for the request and result words.
interface ppt_in_if;
    logic              valid;
    logic              ready;
    ppt_pkg::t_op      operation;
    ppt_pkg::t_id      item_id;
    ppt_pkg::t_payload item_payload;

    modport source (output valid, output operation, output item_id, output item_payload,
                    input ready);
    modport sink   (input valid, input operation, input item_id, input item_payload,
                    output ready);
endinterface

interface ppt_out_if;
    logic              valid;
    logic              ready;
    ppt_pkg::t_status  status;
    ppt_pkg::t_id      result_id;
    ppt_pkg::t_payload result_payload;
    ppt_pkg::t_prio    result_priority;
    logic              id_present;

    modport source (output valid, output status, output result_id, output result_payload,
                    output result_priority, output id_present, input ready);
    modport sink   (input valid, input status, input result_id, input result_payload,
                    input result_priority, input id_present, output ready);
endinterface

// ===== rtl/ppt_cell.sv =====
// One table slot: holds an entry and updates the token passing through it.
module ppt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppt_pkg::t_idx  i_slot,
    input  ppt_pkg::t_tok  i_tok,
    input  ppt_pkg::t_ctl  i_ctl,
    output ppt_pkg::t_tok  o_tok
);
    import ppt_pkg::*;

    logic     r_valid;
    t_id      r_id;
    t_prio    r_prio;
    t_payload r_pay;
    t_tok     r_tok;

    logic     n_valid;
    t_id      n_id;
    t_prio    n_prio;
    t_payload n_pay;
    t_tok     n_tok;

    logic     w_match;
    logic     w_better;

    assign w_match  = r_valid && (r_id == i_tok.key);
    assign w_better = r_valid && (!i_tok.hit || (r_prio > i_tok.r_prio) ||
                      ((r_prio == i_tok.r_prio) && (r_id > i_tok.r_id)));

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_prio  = r_prio;
        n_pay   = r_pay;
        n_tok   = i_tok;
        if (i_tok.vld) begin
            case (i_tok.op)
                OP_ADD: begin
                    // The first free slot along the row takes the new entry.
                    if (i_tok.add_en && !i_tok.placed && !r_valid) begin
                        n_valid      = 1'b1;
                        n_id         = i_tok.new_id;
                        n_prio       = '0;
                        n_pay        = i_tok.payload;
                        n_tok.placed = 1'b1;
                        n_tok.hit    = 1'b1;
                        n_tok.r_id   = i_tok.new_id;
                        n_tok.r_prio = '0;
                        n_tok.r_pay  = i_tok.payload;
                    end
                end
                OP_PROMOTE: begin
                    if (w_match) begin
                        if (!(&r_prio)) begin
                            n_prio = r_prio + 1'b1;
                        end
                        n_tok.hit    = 1'b1;
                        n_tok.r_id   = r_id;
                        n_tok.r_prio = n_prio;
                        n_tok.r_pay  = r_pay;
                    end
                end
                OP_LOOKUP: begin
                    if (w_match) begin
                        n_tok.hit    = 1'b1;
                        n_tok.r_id   = r_id;
                        n_tok.r_prio = r_prio;
                        n_tok.r_pay  = r_pay;
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (w_better) begin
                        n_tok.hit      = 1'b1;
                        n_tok.best_idx = i_slot;
                        n_tok.r_id     = r_id;
                        n_tok.r_prio   = r_prio;
                        n_tok.r_pay    = r_pay;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_ctl.clr && (i_ctl.clr_idx == i_slot)) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_tok.vld <= n_tok.vld;
        end
        r_id   <= n_id;
        r_prio <= n_prio;
        r_pay  <= n_pay;
        r_tok.op       <= n_tok.op;
        r_tok.key      <= n_tok.key;
        r_tok.new_id   <= n_tok.new_id;
        r_tok.payload  <= n_tok.payload;
        r_tok.add_en   <= n_tok.add_en;
        r_tok.placed   <= n_tok.placed;
        r_tok.hit      <= n_tok.hit;
        r_tok.best_idx <= n_tok.best_idx;
        r_tok.r_id     <= n_tok.r_id;
        r_tok.r_prio   <= n_tok.r_prio;
        r_tok.r_pay    <= n_tok.r_pay;
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/promotable_priority_table_unit.sv =====
// Top level: request intake, row of slot cells, result register and id counter.
//
// Use: requests arrive as words on i_in (operation, item_id, item_payload) and
// each gives exactly one result word on o_out (status, result_id,
// result_payload, result_priority, id_present). Both channels move a word on
// a clock edge where valid and ready are high.
// A request enters a row of CAPACITY cells as a token and visits one cell
// per cycle; the cells place new entries, promote or match ids, and track the
// running maximum. After the last cell the token is held in r_fin, then the
// result register loads; o_out.valid and i_in.ready rise in the same cycle,
// so the next request is accepted only after the previous result is loaded.
// i_in.ready is high only while no request is inside the row.
// A result that is not taken holds o_out; a finished request then waits in a
// holding register and the next request is not accepted until it is loaded.
// Reset (synchronous, active low) empties the table, zeroes the id counter
// and drops all valid flags; stored entries need no clearing pass.
module promotable_priority_table_unit (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ppt_in_if.sink  i_in,
    ppt_out_if.source o_out
);
    import ppt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state   r_state, n_state;
    t_cnt     r_cnt;
    t_tok     r_fin;
    t_tok     w_tok [CAPACITY+1];
    t_ctl     w_ctl;
    logic     w_accept;
    logic     w_load;

    logic     r_out_valid;
    t_status  r_status, n_status;
    t_id      r_res_id, n_res_id;
    t_payload r_res_pay, n_res_pay;
    t_prio    r_res_prio, n_res_prio;
    logic     r_present, n_present;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        w_tok[0]          = '0;
        w_tok[0].vld      = w_accept;
        w_tok[0].op       = i_in.operation;
        w_tok[0].key      = i_in.item_id;
        w_tok[0].payload  = i_in.item_payload;
        w_tok[0].new_id   = r_cnt[ID_BITS-1:0];
        w_tok[0].add_en   = (i_in.operation == OP_ADD) && !r_cnt[ID_BITS];
    end

    // A pop removes the winning slot once the result is committed.
    assign w_ctl.clr     = w_load && r_fin.hit && (r_fin.op == OP_POP);
    assign w_ctl.clr_idx = r_fin.best_idx;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ppt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_slot  (IDX_W'(g)),
            .i_tok   (w_tok[g]),
            .i_ctl   (w_ctl),
            .o_tok   (w_tok[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok[CAPACITY].vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_status   = ST_OK;
        n_res_id   = '0;
        n_res_pay  = '0;
        n_res_prio = '0;
        n_present  = 1'b0;
        if (r_fin.hit) begin
            n_res_id   = r_fin.r_id;
            n_res_pay  = r_fin.r_pay;
            n_res_prio = r_fin.r_prio;
            n_present  = 1'b1;
        end else begin
            case (r_fin.op)
                OP_ADD:                n_status = ST_FULL;
                OP_PROMOTE, OP_LOOKUP: n_status = ST_UNKNOWN;
                OP_POP, OP_PEEK:       n_status = ST_EMPTY;
                default:               n_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load && r_fin.placed) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (r_state == S_SCAN && w_tok[CAPACITY].vld) begin
            r_fin <= w_tok[CAPACITY];
        end
        if (w_load) begin
            r_status   <= n_status;
            r_res_id   <= n_res_id;
            r_res_pay  <= n_res_pay;
            r_res_prio <= n_res_prio;
            r_present  <= n_present;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.result_id       = r_res_id;
    assign o_out.result_payload  = r_res_pay;
    assign o_out.result_priority = r_res_prio;
    assign o_out.id_present      = r_present;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state is not one-hot");

    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[CAPACITY].vld |-> (r_state == S_SCAN))
        else $error("token left the row outside of a scan");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN))
        else $error("accepted word did not start a scan");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[ID_BITS] |-> (r_cnt[ID_BITS-1:0] == '0))
        else $error("id counter ran past its limit");

    a_load_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid)
        else $error("committed result did not reach the output register");
`endif

endmodule
